[sv/bslp_pkg.sv]
// ----------------------------------------------------------------------------
// bslp_pkg
// Shared types, constants and functions of the button press cycler.
// ----------------------------------------------------------------------------
package bslp_pkg;

  localparam int unsigned LEVELS = 5;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned INT_W = 8;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS = 2'd1;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd3000;
  localparam logic [IDX_W-1:0] BRIGHT_RESET = 3'd3;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             press_kind;
    logic [IDX_W-1:0] level_index;
    logic [INT_W-1:0] intensity;
  } bslp_result_t;

  // Brightness table, 255 times 0.0, 0.1, 0.3, 0.6 and 1.0, rounded half up.
  function automatic logic [INT_W-1:0] intensity_lookup(input logic [IDX_W-1:0] idx);
    logic [INT_W-1:0] val;
    case (idx)
      3'd0: val = 8'd0;
      3'd1: val = 8'd26;
      3'd2: val = 8'd77;
      3'd3: val = 8'd153;
      default: val = 8'd255;
    endcase
    return val;
  endfunction

  // Next index after a short press, wrapped into the level count.
  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + (IDX_W+1)'(1);
    for (int i = 0; i < 4; i++) begin
      if (sum >= (IDX_W+1)'(LEVELS)) begin
        sum = sum - (IDX_W+1)'(LEVELS);
      end
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[sv/bslp_core.sv]
// ----------------------------------------------------------------------------
// bslp_core
// Press detector state machine with configuration registers and brightness
// index; gives the result of the item being accepted in the same cycle.
// ----------------------------------------------------------------------------
module bslp_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bslp_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [bslp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_fire,
  input  logic                            button_level,
  output bslp_pkg::bslp_result_t          result
);
  import bslp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HOLD = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             last_level_r;
  logic [CNT_W-1:0] since_press_r, since_press_nxt;
  logic [CNT_W-1:0] hold_count_r, hold_count_nxt;
  logic [IDX_W-1:0] bright_r, bright_nxt;
  logic [CNT_W-1:0] debounce_r;
  logic [CNT_W-1:0] long_press_r;
  logic [CNT_W-1:0] since_inc;
  logic [CNT_W-1:0] hold_inc;

  assign since_inc = (since_press_r == CNT_MAX) ? since_press_r : since_press_r + CNT_W'(1);
  assign hold_inc = (hold_count_r == CNT_MAX) ? hold_count_r : hold_count_r + CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    since_press_nxt = since_inc;
    hold_count_nxt = hold_count_r;
    bright_nxt = bright_r;
    result.valid = 1'b0;
    result.press_kind = KIND_SHORT;
    case (phase_r)
      PH_HOLD: begin
        if (!button_level) begin
          bright_nxt = next_index(bright_r);
          result.valid = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          hold_count_nxt = hold_inc;
          if (hold_inc >= long_press_r) begin
            result.valid = 1'b1;
            result.press_kind = KIND_LONG;
            phase_nxt = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        if (!button_level) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (button_level && !last_level_r && (since_inc > debounce_r)) begin
          since_press_nxt = '0;
          hold_count_nxt = '0;
          phase_nxt = PH_HOLD;
        end
      end
    endcase
    result.valid = result.valid & item_fire;
    result.level_index = bright_nxt;
    result.intensity = intensity_lookup(bright_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      last_level_r <= 1'b0;
      since_press_r <= '0;
      hold_count_r <= '0;
      bright_r <= BRIGHT_RESET;
      debounce_r <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: debounce_r <= cfg_data;
          CFG_LONG_PRESS: long_press_r <= cfg_data;
          default: ;
        endcase
      end
      if (item_fire) begin
        phase_r <= phase_nxt;
        last_level_r <= button_level;
        since_press_r <= since_press_nxt;
        hold_count_r <= hold_count_nxt;
        bright_r <= bright_nxt;
      end
    end
  end

endmodule

[sv/button_short_long_press_cycler_top.sv]
// ----------------------------------------------------------------------------
// button_short_long_press_cycler_top
// Debounced short and long press detector driving a five-step brightness
// cycler, one item per millisecond tick.
//
//   Channel | Ports                                    | Moves
//   in      | in_valid, in_ready, in_button_level      | one sampled tick
//   out     | out_valid, out_ready, out_press_kind,    | zero or one press
//           | out_level_index, out_intensity           | event per tick
//   cfg     | cfg_we, cfg_index, cfg_data              | register write
//
// An item is accepted every cycle while in_ready is high; its result is
// registered in the output register, or in the skid register while the output
// register waits. A skid register behind the output register lets one more
// item be accepted while a result waits; in_ready drops only while the skid
// register is full. Reset is synchronous.
// ----------------------------------------------------------------------------
module button_short_long_press_cycler_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bslp_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [bslp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_button_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_press_kind,
  output logic [bslp_pkg::IDX_W-1:0]      out_level_index,
  output logic [bslp_pkg::INT_W-1:0]      out_intensity
);
  import bslp_pkg::*;

  logic         item_fire;
  bslp_result_t result;
  logic         out_valid_r;
  logic         skid_valid_r;
  bslp_result_t out_data_r;
  bslp_result_t skid_data_r;
  logic         out_free;

  assign in_ready = !skid_valid_r;
  assign item_fire = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  bslp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_fire    (item_fire),
    .button_level (in_button_level),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= skid_valid_r || result.valid;
        skid_valid_r <= 1'b0;
      end else if (result.valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end else if (result.valid) begin
      skid_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_press_kind = out_data_r.press_kind;
  assign out_level_index = out_data_r.level_index;
  assign out_intensity = out_data_r.intensity;

endmodule

[tb/tb_button_short_long_press_cycler_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_short_long_press_cycler_top
// Self-checking bench for the button press cycler. A driver feeds sampled
// button ticks from a queue and a monitor predicts the short and long press
// events and compares each one with the block's output, field by field.
// Phases change the debounce and long press settings and the idle patterns.
// ----------------------------------------------------------------------------
module tb_button_short_long_press_cycler_top;
  import bslp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE3 = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;

  typedef enum logic [1:0] {ST_IDLE, ST_HOLD, ST_RELEASE_WAIT} press_state_t;

  typedef struct packed {
    logic             press_kind;
    logic [IDX_W-1:0] level_index;
    logic [INT_W-1:0] intensity;
  } press_event_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_button_level;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_press_kind;
  logic [IDX_W-1:0]      out_level_index;
  logic [INT_W-1:0]      out_intensity;

  logic         level_q[$];
  press_event_t press_q[$];

  int send_idle_pct;
  int stall_pct;
  int mismatch_count;
  int quiet_cycles;
  logic in_taken;

  logic [CNT_W-1:0] debounce_limit;
  logic [CNT_W-1:0] long_limit;
  logic             prev_level;
  press_state_t     press_state;
  logic [CNT_W-1:0] ticks_since_press;
  logic [CNT_W-1:0] held_ticks;
  logic [IDX_W-1:0] bright_idx;

  button_short_long_press_cycler_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_button_level (in_button_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_press_kind  (out_press_kind),
    .out_level_index (out_level_index),
    .out_intensity   (out_intensity)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [INT_W-1:0] brightness_of(input logic [IDX_W-1:0] idx);
    logic [INT_W-1:0] val;
    case (idx)
      3'd0: val = 8'd0;
      3'd1: val = 8'd26;
      3'd2: val = 8'd77;
      3'd3: val = 8'd153;
      default: val = 8'd255;
    endcase
    return val;
  endfunction

  function automatic press_event_t press_event(input logic kind);
    press_event_t ev;
    ev.press_kind = kind;
    ev.level_index = bright_idx;
    ev.intensity = brightness_of(bright_idx);
    return ev;
  endfunction

  task automatic predict_tick(input logic lvl);
    if (ticks_since_press != CNT_MAX) ticks_since_press++;
    case (press_state)
      ST_HOLD: begin
        if (!lvl) begin
          bright_idx = IDX_W'((32'(bright_idx) + 1) % LEVELS);
          press_q.push_back(press_event(KIND_SHORT));
          press_state = ST_IDLE;
        end else begin
          if (held_ticks != CNT_MAX) held_ticks++;
          if (held_ticks >= long_limit) begin
            press_q.push_back(press_event(KIND_LONG));
            press_state = ST_RELEASE_WAIT;
          end
        end
      end
      ST_RELEASE_WAIT: begin
        if (!lvl) press_state = ST_IDLE;
      end
      default: begin
        press_state = ST_IDLE;
        if (lvl && !prev_level && ticks_since_press > debounce_limit) begin
          ticks_since_press = '0;
          held_ticks = '0;
          press_state = ST_HOLD;
        end
      end
    endcase
    prev_level = lvl;
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_press_event();
    press_event_t want;
    if (press_q.size() == 0) begin
      report_mismatch($sformatf("press event kind %0b index %0d with none expected",
                                out_press_kind, out_level_index));
    end else begin
      want = press_q.pop_front();
      if (out_press_kind !== want.press_kind)
        report_mismatch($sformatf("press_kind got %0b expected %0b",
                                  out_press_kind, want.press_kind));
      if (out_level_index !== want.level_index)
        report_mismatch($sformatf("level_index got %0d expected %0d",
                                  out_level_index, want.level_index));
      if (out_intensity !== want.intensity)
        report_mismatch($sformatf("intensity got %0d expected %0d",
                                  out_intensity, want.intensity));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_valid && in_ready;
      if (out_valid && out_ready) check_press_event();
      if (in_taken) predict_tick(in_button_level);
      if (in_taken || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (level_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_button_level <= level_q.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_button_level <= 1'($urandom_range(1));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb_button_short_long_press_cycler_top: errors");
    $finish;
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_DEBOUNCE: debounce_limit = data;
      CFG_LONG_PRESS: long_limit = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (level_q.size() != 0 || in_valid || press_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_ticks(input logic lvl, input int count);
    repeat (count) level_q.push_back(lvl);
  endtask

  task automatic queue_pattern(input logic [31:0] bits, input int len);
    for (int i = len - 1; i >= 0; i--) level_q.push_back(bits[i]);
  endtask

  task automatic queue_random_presses(input int debounce, input int hold_limit, input int n);
    int made;
    int gap;
    int hold;
    int burst;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 75) begin
        gap = $urandom_range(debounce + 3, 1);
        hold = (hold_limit < 16) ? $urandom_range(hold_limit + 3, 1) : $urandom_range(8, 1);
        queue_ticks(1'b0, gap);
        queue_ticks(1'b1, hold);
        made += gap + hold;
      end else begin
        burst = $urandom_range(6, 1);
        repeat (burst) level_q.push_back(1'($urandom_range(1)));
        made += burst;
      end
    end
  endtask

  task automatic run_phase(input int debounce, input int hold_limit, input int idle_pct,
                           input int hold_off_pct, input int n);
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(debounce));
    write_reg(CFG_LONG_PRESS, CFG_DATA_W'(hold_limit));
    send_idle_pct = idle_pct;
    stall_pct = hold_off_pct;
    queue_random_presses(debounce, hold_limit, n);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_DEBOUNCE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_button_level = 1'b0;
    out_ready = 1'b0;
    in_taken = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    debounce_limit = DEBOUNCE_RESET;
    long_limit = LONG_PRESS_RESET;
    prev_level = 1'b0;
    press_state = ST_IDLE;
    ticks_since_press = '0;
    held_ticks = '0;
    bright_idx = BRIGHT_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Edges right after reset fall inside the debounce window.
    queue_pattern(32'b10110100101110, 14);
    wait_drained();

    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_LONG_PRESS, 16'd0);
    write_reg(CFG_SPARE2, 16'hFFFF);
    write_reg(CFG_SPARE3, 16'h5A5A);
    queue_pattern(32'b1110101010, 10);
    wait_drained();

    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_LONG_PRESS, 16'hFFFF);
    queue_pattern(32'b101, 3);
    wait_drained();

    run_phase(2, 4, 0, 0, 100);
    run_phase(0, 1, 65, 0, 80);
    run_phase(5, 12, 0, 65, 80);
    run_phase(1, 3, 31, 31, 80);
    run_phase(3, 65535, 0, 0, 40);
    run_phase(0, 0, 31, 31, 40);

    if (mismatch_count == 0) begin
      $display("tb_button_short_long_press_cycler_top: clean");
    end else begin
      $display("tb_button_short_long_press_cycler_top: errors");
    end
    $finish;
  end

endmodule
